### src/fstp_pkg.sv
`timescale 1ns / 1ps
package fstp_pkg;

   localparam int DW = 32;
   localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

   // register indexes
   localparam logic [1:0] REG_KP = 2'd0;
   localparam logic [1:0] REG_KI = 2'd1;
   localparam logic [1:0] REG_KD = 2'd2;

   // datapath commands
   typedef enum logic [2:0] {
      CMD_NONE, CMD_LOAD, CMD_FUZZ, CMD_GAIN, CMD_MUL, CMD_DONE
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] sel;   // which gain / product term
   } ctl_type;

   typedef struct packed {
      logic fuzz_done;   // last rule row being scanned
      logic mul_done;
   } sts_type;

   // set breakpoints in units of the given scale, rows a,b,c
   function automatic logic signed [19:0] set_pt(input logic [1:0] tab,
                                                  input logic [2:0] s,
                                                  input logic [1:0] k);
      logic signed [19:0] u [7][3];
      logic signed [19:0] p [7][3];
      logic signed [19:0] q [7][3];
      begin
         u = '{'{-20'sd196608, -20'sd65536, 20'sd0},
               '{-20'sd196608, -20'sd131072, 20'sd0},
               '{-20'sd196608, -20'sd65536, 20'sd65536},
               '{-20'sd131072, 20'sd0, 20'sd131072},
               '{-20'sd65536, 20'sd65536, 20'sd196608},
               '{20'sd0, 20'sd131072, 20'sd196608},
               '{20'sd65536, 20'sd196608, 20'sd0}};
         p = '{'{-20'sd19661, -20'sd6554, 20'sd0},
               '{-20'sd19661, -20'sd13107, 20'sd0},
               '{-20'sd19661, -20'sd6554, 20'sd6554},
               '{-20'sd13107, 20'sd0, 20'sd13107},
               '{-20'sd6554, 20'sd6554, 20'sd19661},
               '{20'sd0, 20'sd13107, 20'sd19661},
               '{20'sd6554, 20'sd19661, 20'sd0}};
         q = '{'{-20'sd3932, -20'sd1311, 20'sd0},
               '{-20'sd3932, -20'sd2621, 20'sd0},
               '{-20'sd3932, -20'sd1311, 20'sd1311},
               '{-20'sd2621, 20'sd0, 20'sd2621},
               '{-20'sd1311, 20'sd1311, 20'sd3932},
               '{20'sd0, 20'sd2621, 20'sd3932},
               '{20'sd1311, 20'sd3932, 20'sd0}};
         case (tab)
            2'd0:    set_pt = p[s][k];
            2'd1:    set_pt = q[s][k];
            default: set_pt = u[s][k];
         endcase
      end
   endfunction

   function automatic logic [2:0] rule(input logic [1:0] tab, input logic [2:0] i,
                                       input logic [2:0] j);
      logic [2:0] kp [7][7];
      logic [2:0] ki [7][7];
      logic [2:0] kd [7][7];
      begin
         kp = '{'{6,6,5,5,4,3,3},'{6,6,5,4,4,3,3},'{5,5,5,4,3,2,2},'{5,5,4,3,2,1,1},
                '{4,4,3,2,2,1,1},'{4,3,2,1,1,1,0},'{3,3,1,1,1,0,0}};
         ki = '{'{0,0,1,1,2,3,3},'{0,0,1,2,2,3,3},'{0,1,2,2,3,4,4},'{1,1,2,3,4,5,5},
                '{1,2,3,4,4,5,6},'{3,3,4,4,5,6,6},'{3,3,4,5,5,6,6}};
         kd = '{'{4,2,0,0,0,1,4},'{4,2,0,1,1,2,3},'{3,2,1,1,2,2,3},'{3,2,2,2,2,2,3},
                '{3,3,3,3,3,3,3},'{6,2,4,4,4,4,6},'{6,5,5,5,4,4,6}};
         case (tab)
            2'd0:    rule = kp[i][j];
            2'd1:    rule = ki[i][j];
            default: rule = kd[i][j];
         endcase
      end
   endfunction

   // membership of x in a unit set; slopes are 1 or 1/2 so quotients are shifts
   function automatic logic [16:0] member(input logic signed [33:0] x,
                                          input logic [2:0] s);
      logic signed [33:0] a, b, c;
      logic signed [33:0] d;
      begin
         a = 34'(set_pt(2'd2, s, 2'd0));
         b = 34'(set_pt(2'd2, s, 2'd1));
         c = 34'(set_pt(2'd2, s, 2'd2));
         member = '0;
         if (s == 3'd0) begin
            if (x <= a) member = 17'd65536;
            else if (x <= b) begin
               d = b - x;
               member = 17'(d >>> 1);
            end
         end else if (s == 3'd6) begin
            if (x >= b) member = 17'd65536;
            else if (x > a) begin
               d = x - a;
               member = 17'(d >>> 1);
            end
         end else begin
            if (x > a && x <= b) begin
               d = x - a;
               member = (b - a == 34'sd65536) ? 17'(d) : 17'(d >>> 1);
            end else if (x > b && x <= c) begin
               d = c - x;
               member = (c - b == 34'sd65536) ? 17'(d) : 17'(d >>> 1);
            end
         end
      end
   endfunction

endpackage

### src/fstp_ctrl.sv
`timescale 1ns / 1ps
module fstp_ctrl
   import fstp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output ctl_type ctl,
   input  sts_type sts
);

   typedef enum logic [2:0] {S_IDLE, S_FUZZ, S_GAIN, S_MUL, S_OUT} state_type;

   state_type  state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic       rv_ff, rv_in;

   // sequencer
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      rv_in    = rv_ff;
      ctl      = '{cmd: CMD_NONE, sel: sel_ff};
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_tvalid) begin
            ctl.cmd  = CMD_LOAD;
            state_in = S_FUZZ;
         end
         S_FUZZ: begin
            ctl.cmd  = CMD_FUZZ;
            sel_in   = '0;
            if (sts.fuzz_done) state_in = S_GAIN;
         end
         S_GAIN: begin
            ctl.cmd = CMD_GAIN;
            if (sel_ff == REG_KD) begin
               sel_in   = '0;
               state_in = S_MUL;
            end else sel_in = sel_ff + 2'd1;
         end
         S_MUL: begin
            ctl.cmd = CMD_MUL;
            if (sts.mul_done) begin
               if (sel_ff == REG_KD) state_in = S_OUT;
               else sel_in = sel_ff + 2'd1;
            end
         end
         S_OUT: if (!rv_ff || rsp_tready) begin
            ctl.cmd  = CMD_DONE;
            rv_in    = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         rv_ff    <= rv_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_out: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_DONE) |=> rsp_tvalid) else $error("result lost");
   a_gain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FUZZ && sts.fuzz_done) |=> (state_ff == S_GAIN && sel_ff == 2'd0))
      else $error("bad gain start");

endmodule

### src/fstp_dp.sv
`timescale 1ns / 1ps
module fstp_dp
   import fstp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctl_type       ctl,
   output sts_type       sts,
   input  logic [63:0]   req_tdata,
   input  logic          csr_valid,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_data,
   output logic [31:0]   out_value,
   output logic          out_flag
);

   logic signed [DW-1:0] e_ff, e1_ff, e2_ff;
   logic signed [DW-1:0] g_ff [3];
   logic signed [33:0]   ec_ff;
   logic [16:0]          w_ff;
   logic [2:0]           bi_ff, bj_ff;
   logic [2:0]           row_ff;    // rule row under scan
   logic                 flag_ff;
   logic signed [95:0]   acc_ff;
   logic [1:0]           ph_ff;     // partial product phase
   logic signed [DW-1:0] y_ff;
   logic                 yf_ff;

   // input error, clamped
   logic signed [32:0] e_full;
   logic signed [DW-1:0] e_cl;
   logic               e_ov;
   always_comb begin
      e_full = 33'(signed'(req_tdata[31:0])) - 33'(signed'(req_tdata[63:32]));
      e_ov   = (e_full > 33'(VMAX)) || (e_full < 33'(VMIN));
      e_cl   = (e_full > 33'(VMAX)) ? VMAX : (e_full < 33'(VMIN)) ? VMIN : e_full[31:0];
   end

   // fuzzify and scan one row of cell strengths per cycle, first max wins
   logic [16:0] mrow;
   logic [16:0] mc [7];
   logic [16:0] rbest, cmin;
   logic [2:0]  rj;
   always_comb begin
      mrow = member(34'(e_ff), row_ff);
      for (int k = 0; k < 7; k++) mc[k] = member(ec_ff, 3'(k));
      rbest = '0; rj = '0;
      for (int j = 0; j < 7; j++) begin
         cmin = (mrow < mc[j]) ? mrow : mc[j];
         if (cmin > rbest) begin
            rbest = cmin; rj = 3'(j);
         end
      end
   end

   // defuzzify one gain delta
   logic [2:0]         rs;
   logic signed [19:0] pa, pb, pc;
   logic signed [51:0] num;
   logic signed [33:0] delta;
   logic signed [34:0] gsum;
   logic signed [DW-1:0] gcl;
   logic                 gov;
   always_comb begin
      rs = rule(ctl.sel, bi_ff, bj_ff);
      pa = set_pt(ctl.sel, rs, 2'd0);
      pb = set_pt(ctl.sel, rs, 2'd1);
      pc = set_pt(ctl.sel, rs, 2'd2);
      if (rs == 3'd0) begin
         num   = (52'(pb) <<< 16) - 52'(pb - pa) * 52'(signed'({1'b0, w_ff})) + 52'sd32768;
         delta = 34'(num >>> 16);
      end else if (rs == 3'd6) begin
         num   = (52'(pa) <<< 16) + 52'(pb - pa) * 52'(signed'({1'b0, w_ff})) + 52'sd32768;
         delta = 34'(num >>> 16);
      end else begin
         num   = (52'(pa + pc) <<< 16)
               + 52'(2 * pb - pa - pc) * 52'(signed'({1'b0, w_ff})) + 52'sd65536;
         delta = 34'(num >>> 17);
      end
      gsum = 35'(g_ff[ctl.sel]) + 35'(delta);
      gov  = (gsum > 35'(VMAX)) || (gsum < 35'(VMIN));
      gcl  = (gsum > 35'(VMAX)) ? VMAX : (gsum < 35'(VMIN)) ? VMIN : gsum[31:0];
   end

   // one 32x18 signed partial product per cycle: gain x error term (term split in two halves)
   logic signed [DW-1:0] mg;
   logic signed [33:0]   md;
   logic signed [17:0]   half;
   logic signed [50:0]   pp;
   logic signed [95:0]   term;
   always_comb begin
      mg = g_ff[ctl.sel];
      case (ctl.sel)
         REG_KP:  md = 34'(e_ff) - 34'(e1_ff);
         REG_KI:  md = 34'(e_ff);
         default: md = -(34'(e_ff) - (34'(e1_ff) <<< 1) + 34'(e2_ff));
      endcase
      // upper half is signed, lower half is a plain magnitude
      half = ph_ff[0] ? 18'(signed'(md[33:17])) : 18'(signed'({1'b0, md[16:0]}));
      pp   = 51'(mg) * 51'(half);
      term = ph_ff[0] ? (96'(pp) <<< 17) : 96'(pp);
   end
   assign sts = '{fuzz_done: (row_ff == 3'd6), mul_done: ph_ff[0]};

   // output rounding and clamp
   logic signed [95:0] rnd;
   logic signed [79:0] sh;
   logic               yov;
   always_comb begin
      rnd = acc_ff + 96'sd32768;
      sh  = 80'(rnd >>> 16);
      yov = (sh > 80'(VMAX)) || (sh < 80'(VMIN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ff  <= '0; e2_ff <= '0;
         g_ff   <= '{default: '0};
         ph_ff  <= '0;
         row_ff <= '0;
      end else begin
         if (csr_valid && csr_index != 2'd3) g_ff[csr_index] <= csr_data;
         case (ctl.cmd)
            CMD_LOAD: begin
               e_ff    <= e_cl;
               flag_ff <= e_ov;
               ec_ff   <= 34'(e_cl) - 34'(e1_ff);
               acc_ff  <= '0;
               ph_ff   <= '0;
               row_ff  <= '0;
               w_ff    <= '0; bi_ff <= '0; bj_ff <= '0;
            end
            CMD_FUZZ: begin
               if (rbest > w_ff) begin
                  w_ff <= rbest; bi_ff <= row_ff; bj_ff <= rj;
               end
               if (row_ff != 3'd6) row_ff <= row_ff + 3'd1;
            end
            CMD_GAIN: begin
               g_ff[ctl.sel] <= gcl;
               if (gov) flag_ff <= 1'b1;
            end
            CMD_MUL: begin
               acc_ff <= acc_ff + term;
               ph_ff  <= {1'b0, ~ph_ff[0]};
            end
            CMD_DONE: begin
               y_ff  <= yov ? (rnd[95] ? VMIN : VMAX) : sh[31:0];
               yf_ff <= flag_ff | yov;
               e2_ff <= e1_ff;
               e1_ff <= e_ff;
            end
            default: ;
         endcase
      end
   end

   assign out_value = y_ff;
   assign out_flag  = yf_ff;

   a_ph: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd != CMD_MUL && ctl.cmd != CMD_LOAD) |=> ($stable(ph_ff)))
      else $error("phase moved");
   a_hist: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_DONE) |=> (e2_ff == $past(e1_ff))) else $error("history");
   a_flag: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_GAIN && gov) |=> flag_ff) else $error("flag lost");

endmodule

### src/fuzzy_self_tuning_pid_top.sv
`timescale 1ns / 1ps
// channel | dir | ports                         | content
// req     | in  | req_tvalid/tready/tdata[63:0] | setpoint, feedback
// rsp     | out | rsp_tvalid/tready/tdata[31:0] | drive_increment; tuser = saturated
// csr     | in  | csr_valid/ready/index/data    | initial gains 0..2
// Each sample runs load, seven fuzzify steps (one rule row each),
// three gain updates, the three products on the shared 32x18 multiplier, then output.
// Synchronous active-high reset clears history and running gains to zero.
// A held result stalls the block only until taken; next sample waits for idle.
module fuzzy_self_tuning_pid_top
   import fstp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // setpoint[31:0], feedback[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // drive_increment[31:0]
   output logic        rsp_tuser,   // saturated
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   fstp_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .ctl, .sts
   );

   fstp_dp u_dp (
      .clock, .reset, .ctl, .sts, .req_tdata, .csr_valid, .csr_index, .csr_data,
      .out_value(rsp_tdata), .out_flag(rsp_tuser)
   );

endmodule
